### hw/rtl/xmcr_pkg.sv
// ============================================================================
// xmcr_pkg
// Shared constants, codes and controller/datapath handshake types for the
// XMODEM checksum receiver.
// ============================================================================
package xmcr_pkg;

    // Default geometry, handed to the top-level parameters
    localparam int unsigned PAGE_BYTES_DEF      = 128;
    localparam int unsigned FLASH_ADDR_BITS_DEF = 24;

    // Timeout register reset value
    localparam logic [15:0] TIMEOUT_RST = 16'd30000;

    // Protocol bytes
    localparam logic [7:0] HDR_SOH = 8'h01;
    localparam logic [7:0] HDR_EOT = 8'h04;
    localparam logic [7:0] RPL_ACK = 8'h06;
    localparam logic [7:0] RPL_NAK = 8'h15;

    // Request type codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;

    // Receive phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NUMBER,
        PH_INVERSE,
        PH_DATA,
        PH_SUM
    } t_phase;

    // What one request asks of the controller
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_NAK,
        ACT_ACK,
        ACT_COMMIT
    } t_action;

    // Which result the output register loads
    typedef enum logic [2:0] {
        OSEL_NAK,
        OSEL_ACK,
        OSEL_ERASE,
        OSEL_WORD,
        OSEL_PAGE_ACK
    } t_out_sel;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_NAK,
        S_ACK,
        S_ERASE,
        S_RD,
        S_WORD,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     latch;     // capture the accepted request
        logic     apply;     // update receiver state from the captured request
        logic     out_load;  // load the output register
        t_out_sel out_sel;
        logic     word_clr;  // restart the page word counter
        logic     word_inc;  // step the page word counter
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_action action;
        logic    erase_pending;
        logic    last_word;
        logic    out_free;
    } t_dp_status;

endpackage

### hw/rtl/xmcr_if.sv
// ============================================================================
// xmcr_if
// Valid/ready channels of the receiver: the request channel and the result
// channel.
// ============================================================================
interface xmcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface xmcr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  reply_byte;
    logic [23:0] flash_addr;
    logic [63:0] page_word;
    logic        last;

    modport source (
        output valid, output out_kind, output reply_byte, output flash_addr,
        output page_word, output last, input ready
    );
    modport sink (
        input valid, input out_kind, input reply_byte, input flash_addr,
        input page_word, input last, output ready
    );
endinterface

### hw/rtl/xmcr_ctrl.sv
// ============================================================================
// xmcr_ctrl
// Sequencer: takes one request, has the datapath evaluate it, then walks the
// result sequence, if any (reply, or erase / page words / ACK) into the output
// register.
// ============================================================================
module xmcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  xmcr_pkg::t_dp_status i_status,
    output xmcr_pkg::t_dp_cmd  o_cmd
);
    import xmcr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.apply = 1'b1;
                unique case (i_status.action)
                    ACT_NONE: n_state = S_IDLE;
                    ACT_NAK:  n_state = S_NAK;
                    ACT_ACK:  n_state = S_ACK;
                    ACT_COMMIT: begin
                        if (i_status.erase_pending) begin
                            n_state = S_ERASE;
                        end else begin
                            o_cmd.word_clr = 1'b1;
                            n_state        = S_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_NAK: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_NAK;
                    n_state        = S_IDLE;
                end
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_ACK;
                    n_state        = S_IDLE;
                end
            end
            S_ERASE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_ERASE;
                    o_cmd.word_clr = 1'b1;
                    n_state        = S_RD;
                end
            end
            // buffer read in flight
            S_RD: begin
                n_state = S_WORD;
            end
            S_WORD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_WORD;
                    if (i_status.last_word) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.word_inc = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_PAGE_ACK;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/xmcr_dp.sv
// ============================================================================
// xmcr_dp
// Receiver datapath: protocol state, page buffer memory, timeout register
// and the result output register.
// ============================================================================
module xmcr_dp #(
    parameter int unsigned PAGE_BYTES      = xmcr_pkg::PAGE_BYTES_DEF,
    parameter int unsigned FLASH_ADDR_BITS = xmcr_pkg::FLASH_ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_rx_byte,
    input  xmcr_pkg::t_dp_cmd    i_cmd,
    output xmcr_pkg::t_dp_status o_status,
    xmcr_res_if.source           o_res
);
    import xmcr_pkg::*;

    localparam int unsigned WORDS = (PAGE_BYTES + 7) / 8;
    localparam int unsigned WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned BIW   = $clog2(PAGE_BYTES + 1);
    localparam int unsigned AW    = FLASH_ADDR_BITS;

    // Configuration and captured request
    logic [15:0] r_timeout;
    logic [1:0]  r_req_type;
    logic [7:0]  r_rx_byte;

    // Protocol state
    logic           r_active,     n_active;
    t_phase         r_phase,      n_phase;
    logic [15:0]    r_tick,       n_tick;
    logic [7:0]     r_pnum,       n_pnum;
    logic [7:0]     r_pinv,       n_pinv;
    logic [7:0]     r_last_good,  n_last_good;
    logic [BIW-1:0] r_byte_idx,   n_byte_idx;
    logic [7:0]     r_sum,        n_sum;
    logic           r_erase_pend;
    logic [AW-1:0]  r_page_addr;
    logic           buf_wr;
    logic           open_sess;
    t_action        action;

    // Page buffer, one 64-bit word per row, byte-lane writes
    logic [63:0]    r_mem [WORDS];
    logic [63:0]    r_rdata;
    logic [WIW-1:0] r_word;
    logic [WIW-1:0] wr_row;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_reply;
    logic [23:0] r_out_addr;
    logic [63:0] r_out_word;
    logic        r_out_last;

    logic [16:0]   tick_inc;
    logic [BIW-1:0] idx_inc;
    logic          pkt_good;
    logic [63:0]   word_masked;
    logic [AW-1:0] word_addr;
    logic [WIW+2:0] byte_pos;
    logic          out_free;

    assign tick_inc = {1'b0, r_tick} + 17'd1;
    assign idx_inc  = r_byte_idx + 1'b1;
    assign pkt_good = (r_rx_byte == r_sum) && (r_pnum == (r_pinv ^ 8'hFF))
                   && (r_pnum == 8'(r_last_good + 8'd1));
    assign wr_row   = WIW'(r_byte_idx >> 3);

    // Request evaluation: next protocol state and the action it causes
    always_comb begin
        n_active    = r_active;
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_pnum      = r_pnum;
        n_pinv      = r_pinv;
        n_last_good = r_last_good;
        n_byte_idx  = r_byte_idx;
        n_sum       = r_sum;
        buf_wr      = 1'b0;
        open_sess   = 1'b0;
        action      = ACT_NONE;
        priority if (r_req_type == REQ_START) begin
            open_sess   = 1'b1;
            n_active    = 1'b1;
            n_phase     = PH_HEADER;
            n_tick      = '0;
            n_pnum      = '0;
            n_pinv      = '0;
            n_last_good = '0;
            n_byte_idx  = '0;
            n_sum       = '0;
            action      = ACT_NAK;
        end else if (!r_active) begin
            action = ACT_NONE;
        end else if (r_req_type == REQ_TICK) begin
            if (tick_inc >= {1'b0, r_timeout}) begin
                n_tick  = '0;
                n_phase = PH_HEADER;
                action  = ACT_NAK;
            end else begin
                n_tick = tick_inc[15:0];
            end
        end else if (r_req_type == REQ_BYTE) begin
            n_tick = '0;
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_rx_byte == HDR_EOT) begin
                        n_active = 1'b0;
                        action   = ACT_ACK;
                    end else if (r_rx_byte == HDR_SOH) begin
                        n_phase = PH_NUMBER;
                    end
                end
                PH_NUMBER: begin
                    n_pnum  = r_rx_byte;
                    n_phase = PH_INVERSE;
                end
                PH_INVERSE: begin
                    n_pinv     = r_rx_byte;
                    n_byte_idx = '0;
                    n_sum      = '0;
                    n_phase    = PH_DATA;
                end
                PH_DATA: begin
                    buf_wr     = 1'b1;
                    n_sum      = r_sum + r_rx_byte;
                    n_byte_idx = idx_inc;
                    if (idx_inc >= BIW'(PAGE_BYTES)) begin
                        n_phase = PH_SUM;
                    end
                end
                // checksum byte closes the packet
                default: begin
                    n_phase = PH_HEADER;
                    if (pkt_good) begin
                        n_last_good = r_pnum;
                        action      = ACT_COMMIT;
                    end else begin
                        action = ACT_NAK;
                    end
                end
            endcase
        end else begin
            action = ACT_NONE;
        end
    end

    // Config, request capture and protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_active    <= 1'b0;
            r_phase     <= PH_HEADER;
            r_tick      <= '0;
            r_pnum      <= '0;
            r_pinv      <= '0;
            r_last_good <= '0;
            r_byte_idx  <= '0;
            r_sum       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_cmd.apply) begin
                r_active    <= n_active;
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_pnum      <= n_pnum;
                r_pinv      <= n_pinv;
                r_last_good <= n_last_good;
                r_byte_idx  <= n_byte_idx;
                r_sum       <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req_type <= i_req_type;
            r_rx_byte  <= i_rx_byte;
        end
    end

    // Page buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && buf_wr) begin
            r_mem[wr_row][{r_byte_idx[2:0], 3'b000} +: 8] <= r_rx_byte;
        end
        r_rdata <= r_mem[r_word];
    end

    // Page word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_cmd.word_clr) begin
            r_word <= '0;
        end else if (i_cmd.word_inc) begin
            r_word <= r_word + 1'b1;
        end
    end

    // Zero the lanes past the end of the page
    always_comb begin
        word_masked = '0;
        byte_pos    = '0;
        for (int l = 0; l < 8; l++) begin
            byte_pos = {r_word, 3'(l)};
            if (32'(byte_pos) < 32'(PAGE_BYTES)) begin
                word_masked[l*8 +: 8] = r_rdata[l*8 +: 8];
            end
        end
    end

    assign word_addr = r_page_addr + AW'({r_word, 3'b000});
    assign out_free  = !r_out_valid || o_res.ready;

    // Erase flag and running flash address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_pend <= 1'b1;
            r_page_addr  <= '0;
        end else if (i_cmd.apply && open_sess) begin
            r_erase_pend <= 1'b1;
            r_page_addr  <= '0;
        end else if (i_cmd.out_load) begin
            if (i_cmd.out_sel == OSEL_ERASE) begin
                r_erase_pend <= 1'b0;
            end
            if (i_cmd.out_sel == OSEL_PAGE_ACK) begin
                r_page_addr <= r_page_addr + AW'(PAGE_BYTES);
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind  <= KIND_REPLY;
            r_out_reply <= '0;
            r_out_addr  <= '0;
            r_out_word  <= '0;
            r_out_last  <= 1'b1;
            unique case (i_cmd.out_sel)
                OSEL_NAK: r_out_reply <= RPL_NAK;
                OSEL_ACK, OSEL_PAGE_ACK: r_out_reply <= RPL_ACK;
                OSEL_ERASE: begin
                    r_out_kind <= KIND_ERASE;
                    r_out_last <= 1'b0;
                end
                OSEL_WORD: begin
                    r_out_kind <= KIND_WORD;
                    r_out_addr <= 24'(32'(word_addr));
                    r_out_word <= word_masked;
                    r_out_last <= 1'b0;
                end
                default: r_out_reply <= RPL_NAK;
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_kind   = r_out_kind;
    assign o_res.reply_byte = r_out_reply;
    assign o_res.flash_addr = r_out_addr;
    assign o_res.page_word  = r_out_word;
    assign o_res.last       = r_out_last;

    assign o_status.action        = action;
    assign o_status.erase_pending = r_erase_pend;
    assign o_status.last_word     = (r_word == WIW'(WORDS - 1));
    assign o_status.out_free      = out_free;

endmodule

### hw/rtl/xmodem_checksum_receiver_top.sv
// ============================================================================
// xmodem_checksum_receiver_top
// XMODEM receiver with 8-bit checksum: takes start / byte / tick requests,
// replies ACK or NAK and turns each good packet into page program results,
// preceded by a flash erase for the first packet of a session.
// ============================================================================
//  channel   dir  handshake        payload
//  i_req     in   valid/ready      req_type, rx_byte
//  o_res     out  valid/ready      out_kind, reply_byte, flash_addr,
//                                  page_word, last
//  i_cfg_*   in   write enable     timeout_ticks (16 bits)
//
//  A request passes capture (S_IDLE) and evaluate (S_EVAL); one with a reply
//  then loads it into the output register. A good packet loads an erase on the
//  first block, then each of the ceil(PAGE_BYTES/8) page words after its read
//  through the page buffer RAM's registered read port (S_RD), then the ACK.
//  Each result waits in the output register while o_res.ready is low; the next
//  request is accepted while the final result still waits there.
//  Reset is synchronous; the page buffer is not cleared, every byte of it is
//  written before a commit reads it.
// ============================================================================
module xmodem_checksum_receiver_top #(
    parameter int unsigned PAGE_BYTES      = xmcr_pkg::PAGE_BYTES_DEF,
    parameter int unsigned FLASH_ADDR_BITS = xmcr_pkg::FLASH_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    xmcr_req_if.sink    i_req,
    xmcr_res_if.source  o_res
);
    import xmcr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       req_ready;

    assign i_req.ready = req_ready;

    // Sequencer
    xmcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath
    xmcr_dp #(
        .PAGE_BYTES      (PAGE_BYTES),
        .FLASH_ADDR_BITS (FLASH_ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_type    (i_req.req_type),
        .i_rx_byte     (i_req.rx_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_res         (o_res)
    );

endmodule
